// ===== src/rect_fill_command_stream_macros.svh =====
// ----------------------------------------------------------------------------
// rect_fill_command_stream_macros.svh
// Assertion shorthands used by rfc_back.
// ----------------------------------------------------------------------------
`ifndef RECT_FILL_COMMAND_STREAM_MACROS_SVH
`define RECT_FILL_COMMAND_STREAM_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define RFC_ASSERT_HOLDS(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define RFC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared constants and types of the rectangle fill command stream.
// ----------------------------------------------------------------------------
package rfc_pkg;

    // Coordinate width of the panel (2^COORD_BITS columns/rows at most).
    localparam int COORD_BITS = 10;
    localparam int COUNT_W    = COORD_BITS + 1;

    // Panel size register width, fixed by the config port.
    localparam int SIZE_W = 11;

    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input word kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PULL  = 1'b1;

    // Config register indexes.
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  CFG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0]  CFG_PANEL_HEIGHT = 2'd1;

    // Controller command bytes.
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

    typedef struct packed {
        logic [COORD_BITS-1:0] hi;
        logic [COORD_BITS-1:0] lo;
    } rfc_span_t;

    typedef struct packed {
        logic      kind;
        rfc_span_t col;
        rfc_span_t row;
        logic [15:0] color;
    } rfc_cmd_t;

endpackage

// ===== src/rfc_front.sv =====
// ----------------------------------------------------------------------------
// rfc_front
// Input side: panel size registers, corner ordering and clamping.
// ----------------------------------------------------------------------------
module rfc_front
    import rfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [79:0]          s_data,
    input  logic                 s_user,
    output logic                 push_valid,
    input  logic                 push_ready,
    output rfc_cmd_t             push_cmd
);

    localparam int CMP_W = COORD_BITS + SIZE_W + 1;

    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [COORD_BITS-1:0] col_top;
    logic [COORD_BITS-1:0] row_top;

    // Highest legal index for a panel size; zero counts as one.
    function automatic logic [COORD_BITS-1:0] top_index(input logic [SIZE_W-1:0] size);
        logic [CMP_W-1:0] s;
        logic [CMP_W-1:0] lim;
        begin
            lim = CMP_W'(1) << COORD_BITS;
            s   = CMP_W'(size);
            if (s == '0)
            begin
                s = CMP_W'(1);
            end
            if (s > lim)
            begin
                s = lim;
            end
            top_index = COORD_BITS'(s - CMP_W'(1));
        end
    endfunction

    function automatic rfc_span_t order_clamp(input logic [15:0] a, input logic [15:0] b,
                                              input logic [COORD_BITS-1:0] top);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] t16;
        rfc_span_t   r;
        begin
            t16 = 16'(top);
            lo  = (a > b) ? b : a;
            hi  = (a > b) ? a : b;
            if (lo > t16)
            begin
                lo = t16;
            end
            if (hi > t16)
            begin
                hi = t16;
            end
            r.lo = COORD_BITS'(lo);
            r.hi = COORD_BITS'(hi);
            order_clamp = r;
        end
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(280);
            height_reg <= SIZE_W'(320);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PANEL_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == CFG_PANEL_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    assign col_top = top_index(width_reg);
    assign row_top = top_index(height_reg);

    // tdata: x_first, y_first, x_second, y_second, fill_color
    always_comb
    begin
        push_cmd.kind  = s_user;
        push_cmd.col   = order_clamp(s_data[15:0], s_data[47:32], col_top);
        push_cmd.row   = order_clamp(s_data[31:16], s_data[63:48], row_top);
        push_cmd.color = s_data[79:64];
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

// ===== src/rfc_queue.sv =====
// ----------------------------------------------------------------------------
// rfc_queue
// Short command FIFO decoupling the front and back parts.
// ----------------------------------------------------------------------------
module rfc_queue
    import rfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  rfc_cmd_t push_cmd,
    output logic     head_valid,
    input  logic     pop,
    output rfc_cmd_t head_cmd
);

    rfc_cmd_t          entry_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push       = push_valid && push_ready;
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/rfc_back.sv =====
// ----------------------------------------------------------------------------
// rfc_back
// Byte sequencer: window preamble, pixel burst and the output register.
// ----------------------------------------------------------------------------
`include "rect_fill_command_stream_macros.svh"

module rfc_back
    import rfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  rfc_cmd_t   head_cmd,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data,
    output logic [1:0] m_user,
    output logic       m_last
);

    localparam logic [3:0] STEP_COL_CMD  = 4'd0;
    localparam logic [3:0] STEP_COL_END  = 4'd4;
    localparam logic [3:0] STEP_PAGE_CMD = 4'd5;
    localparam logic [3:0] STEP_ROW_END  = 4'd9;
    localparam logic [3:0] STEP_MEMW_CMD = 4'd10;
    localparam logic [3:0] STEP_BURST    = 4'd11;

    logic                  busy_reg,     busy_next;
    logic [3:0]            step_reg,     step_next;
    logic                  low_half_reg, low_half_next;
    rfc_span_t             col_reg,      col_next;
    rfc_span_t             row_reg,      row_next;
    logic [15:0]           color_reg,    color_next;
    logic [COUNT_W-1:0]    cols_reg,     cols_next;
    logic [COUNT_W-1:0]    rows_reg,     rows_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  is_data_reg,  is_data_next;
    logic                  burst_reg,    burst_next;
    logic                  last_reg,     last_next;
    logic                  emits;
    logic                  out_load;

    function automatic logic [COUNT_W-1:0] span_len(input rfc_span_t s);
        begin
            span_len = COUNT_W'(s.hi) - COUNT_W'(s.lo) + COUNT_W'(1);
        end
    endfunction

    // Window bytes: start hi, start lo, end hi, end lo.
    function automatic logic [7:0] window_byte(input rfc_span_t s, input logic [1:0] k);
        logic [15:0] lo16;
        logic [15:0] hi16;
        begin
            lo16 = 16'(s.lo);
            hi16 = 16'(s.hi);
            unique case (k)
                2'd0:    window_byte = lo16[15:8];
                2'd1:    window_byte = lo16[7:0];
                2'd2:    window_byte = hi16[15:8];
                default: window_byte = hi16[7:0];
            endcase
        end
    endfunction

    assign emits    = head_valid && (head_cmd.kind == KIND_PULL) && busy_reg;
    assign pop      = head_valid && (!emits || !out_valid_reg || m_ready);
    assign out_load = pop && emits;

    always_comb
    begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        low_half_next = low_half_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        color_next    = color_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        out_byte_next = 8'h00;
        is_data_next  = 1'b0;
        burst_next    = 1'b0;
        last_next     = 1'b0;

        if (pop && (head_cmd.kind == KIND_START) && !busy_reg)
        begin
            col_next      = head_cmd.col;
            row_next      = head_cmd.row;
            color_next    = head_cmd.color;
            cols_next     = span_len(head_cmd.col);
            rows_next     = span_len(head_cmd.row);
            step_next     = STEP_COL_CMD;
            low_half_next = 1'b0;
            busy_next     = 1'b1;
        end
        else if (out_load)
        begin
            priority if (step_reg == STEP_COL_CMD)
            begin
                out_byte_next = CMD_COLUMN_SET;
            end
            else if (step_reg <= STEP_COL_END)
            begin
                out_byte_next = window_byte(col_reg, 2'(step_reg - 4'd1));
                is_data_next  = 1'b1;
            end
            else if (step_reg == STEP_PAGE_CMD)
            begin
                out_byte_next = CMD_PAGE_SET;
            end
            else if (step_reg <= STEP_ROW_END)
            begin
                out_byte_next = window_byte(row_reg, 2'(step_reg - 4'd6));
                is_data_next  = 1'b1;
            end
            else if (step_reg == STEP_MEMW_CMD)
            begin
                out_byte_next = CMD_MEMORY_WRITE;
            end
            else
            begin
                is_data_next = 1'b1;
                burst_next   = 1'b1;
                if (!low_half_reg)
                begin
                    out_byte_next = color_reg[15:8];
                    low_half_next = 1'b1;
                end
                else
                begin
                    out_byte_next = color_reg[7:0];
                    low_half_next = 1'b0;
                    priority if (cols_reg > COUNT_W'(1))
                    begin
                        cols_next = cols_reg - COUNT_W'(1);
                    end
                    else if (rows_reg > COUNT_W'(1))
                    begin
                        rows_next = rows_reg - COUNT_W'(1);
                        cols_next = span_len(col_reg);
                    end
                    else
                    begin
                        last_next = 1'b1;
                        busy_next = 1'b0;
                        cols_next = '0;
                        rows_next = '0;
                        step_next = STEP_COL_CMD;
                    end
                end
            end
            if (step_reg < STEP_BURST)
            begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_COL_CMD;
            low_half_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            low_half_reg  <= low_half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        color_reg <= color_next;
        cols_reg  <= cols_next;
        rows_reg  <= rows_next;
        if (out_load)
        begin
            out_byte_reg <= out_byte_next;
            is_data_reg  <= is_data_next;
            burst_reg    <= burst_next;
            last_reg     <= last_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_byte_reg;
    assign m_user  = {burst_reg, is_data_reg};
    assign m_last  = last_reg;

    `RFC_ASSERT_HOLDS(a_last_in_burst, clk, rst_n, m_valid && m_last, m_user[1] && m_user[0], "last byte outside pixel burst")
    `RFC_ASSERT_NEXT(a_last_goes_idle, clk, rst_n, out_load && last_next, !busy_reg && m_valid, "run did not end on last byte")
    `RFC_ASSERT_HOLDS(a_idle_rest, clk, rst_n, !busy_reg, step_reg == STEP_COL_CMD && !low_half_reg, "idle sequencer not at rest")
    `RFC_ASSERT_HOLDS(a_step_range, clk, rst_n, busy_reg, step_reg <= STEP_BURST, "step beyond pixel burst")

endmodule

// ===== src/rect_fill_command_stream.sv =====
// ----------------------------------------------------------------------------
// rect_fill_command_stream - rectangle fill byte stream for an RGB565 panel
// Throughput: one input word per cycle while the queue has room; the sequencer
// retires one queue entry a cycle unless m_axis stalls, and the output register
// accepts a new byte while one is taken; words pass the queue and output register.
// Reset (rst_n low, async): idle, queue empty, output empty, panel 280 x 320.
// ----------------------------------------------------------------------------
module rect_fill_command_stream
    import rfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write channel: index 0 panel_width, 1 panel_height
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    // input words
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [79:0]          s_axis_tdata,  // x_first, y_first, x_second, y_second, fill_color
    input  logic                 s_axis_tuser,  // kind
    // output bytes
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // out_byte
    output logic [1:0]           m_axis_tuser,  // is_data, pixel_burst
    output logic                 m_axis_tlast   // last
);

    // Front: orders corners and clamps them against the panel size at accept time.
    // Queue: holds classified words so the sequencer can stall on its own.
    // Back: steps the 11-byte preamble, then two bytes per pixel, with the
    // output register as the skid point toward m_axis.

    logic     push_valid;
    logic     push_ready;
    rfc_cmd_t push_cmd;
    logic     head_valid;
    logic     pop;
    rfc_cmd_t head_cmd;

    rfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_user     (s_axis_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    rfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .head_cmd   (head_cmd)
    );

    rfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_user     (m_axis_tuser),
        .m_last     (m_axis_tlast)
    );

endmodule
